// ===== sv/packet_filter_rule_table_macros.svh =====
// Assertion macros for the rule table. Empty under synthesis.
`ifndef PACKET_FILTER_RULE_TABLE_MACROS_SVH
`define PACKET_FILTER_RULE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define PFRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfrt: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define PFRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfrt: next-cycle check failed");

`else

`define PFRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/pfrt_pkg.sv =====
package pfrt_pkg;

	localparam int RULE_SLOTS = 16;
	localparam int SLOT_IW    = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] FIRST_NUMBER = 16'd1;
	localparam logic [15:0] NUMBER_MAX   = 16'hFFFF;

	// item modes
	localparam logic [1:0] MODE_CLASSIFY = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_REMOVE   = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef logic [SLOT_IW-1:0] slot_idx_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  protocol;
		logic [15:0] port;
		logic        block_rule;
		logic [15:0] rule_id;
	} in_item_t;

	typedef struct packed {
		logic        drop;
		logic [15:0] result_rule;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic        block;
		logic [7:0]  protocol;
		logic [15:0] port;
		logic [15:0] number;
	} rule_t;

	// sequencer -> rule store
	typedef struct packed {
		logic      rd_en;
		slot_idx_t rd_idx;
		logic      wr_en;
		slot_idx_t wr_idx;
		rule_t     wr_rule;
		logic      clr_en;
		slot_idx_t clr_idx;
	} store_cmd_t;

	// scan unit -> sequencer
	typedef struct packed {
		logic        hit;
		logic [15:0] acc;
		logic        any;
		logic        free_found;
		slot_idx_t   free_idx;
		logic        found;
		slot_idx_t   found_idx;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

// ===== sv/packet_filter_rule_table.sv =====
// Each item is handled by a slot scan that reads one rule per cycle from the rule
//   store into the shared compare unit; no new item is taken until the scan is
//   done and its result is loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): all slots invalid, sequencer idle, no result.
`include "packet_filter_rule_table_macros.svh"

module packet_filter_rule_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pfrt_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pfrt_pkg::out_item_t rsp
);
	import pfrt_pkg::*;

	localparam slot_idx_t LAST_IDX = slot_idx_t'(RULE_SLOTS - 1);

	state_t      state_q;
	state_t      state_d;
	slot_idx_t   idx_q;
	in_item_t    item_q;

	// read pipeline: which slot the store is returning this cycle
	logic        eval_s1;
	slot_idx_t   idx_s1;

	logic        accept;
	logic        start;
	logic        load;
	store_cmd_t  cmd;
	logic        rd_valid_s1;
	rule_t       rd_rule_s1;
	scan_res_t   res;

	out_item_t   rsp_q;
	out_item_t   rsp_d;
	logic        rsp_valid_q;

	logic        add_ok;
	logic [15:0] add_num;

	// Busy from accept until the result is loaded; the output register is independent,
	// so the next item can come in while the previous result still waits.
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	pfrt_rule_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_valid_s1 (rd_valid_s1),
		.rd_rule_s1  (rd_rule_s1)
	);

	pfrt_scan_unit u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.eval       (eval_s1),
		.item       (item_q),
		.slot_idx   (idx_s1),
		.slot_valid (rd_valid_s1),
		.slot       (rd_rule_s1),
		.res        (res)
	);

	// Add outcome: needs a free slot and headroom above the highest number.
	assign add_ok  = res.free_found && !(res.any && (res.acc == NUMBER_MAX));
	assign add_num = res.any ? (res.acc + 16'd1) : FIRST_NUMBER;

	// result word for the item being finished
	always_comb begin
		rsp_d = '0;
		case (item_q.mode)
			MODE_CLASSIFY: begin
				rsp_d.drop        = res.hit;
				rsp_d.result_rule = res.hit ? res.acc : 16'd0;
				rsp_d.status      = STATUS_OK;
			end
			MODE_ADD: begin
				rsp_d.result_rule = add_ok ? add_num : 16'd0;
				rsp_d.status      = add_ok ? STATUS_OK : STATUS_FULL;
			end
			MODE_REMOVE: begin
				rsp_d.status = res.found ? STATUS_OK : STATUS_NOT_FOUND;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// Sequencer: IDLE -> SCAN (one read per slot) -> DRAIN (last compare)
	// -> FINISH (commit table change and load result once the output is free).
	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		load    = 1'b0;
		cmd     = '0;
		cmd.rd_idx          = idx_q;
		cmd.wr_idx          = res.free_idx;
		cmd.wr_rule.block    = item_q.block_rule;
		cmd.wr_rule.protocol = item_q.protocol;
		cmd.wr_rule.port     = item_q.port;
		cmd.wr_rule.number   = add_num;
		cmd.clr_idx         = res.found_idx;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					start   = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load       = 1'b1;
					cmd.wr_en  = (item_q.mode == MODE_ADD) && add_ok;
					cmd.clr_en = (item_q.mode == MODE_REMOVE) && res.found;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			eval_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			eval_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				idx_q <= '0;
			end else if ((state_q == ST_SCAN) && (idx_q != LAST_IDX)) begin
				idx_q <= idx_q + slot_idx_t'(1);
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		idx_s1 <= idx_q;
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// rule numbers start at one, so a drop always names a real rule
	`PFRT_ASSERT_IMPL(a_drop_numbered, clk, arst_n, rsp_valid_q && rsp_q.drop, rsp_q.result_rule != 16'd0)
	`PFRT_ASSERT_IMPL(a_drop_ok, clk, arst_n, rsp_valid_q && rsp_q.drop, rsp_q.status == STATUS_OK)
	`PFRT_ASSERT_IMPL(a_fail_empty, clk, arst_n, rsp_valid_q && (rsp_q.status == STATUS_FULL || rsp_q.status == STATUS_NOT_FOUND), !rsp_q.drop && (rsp_q.result_rule == 16'd0))
	`PFRT_ASSERT_NEXT(a_accept_scan, clk, arst_n, accept, (state_q == ST_SCAN) && (idx_q == '0))

endmodule

// ===== sv/pfrt_rule_store.sv =====
module pfrt_rule_store (
	input  logic                clk,
	input  logic                arst_n,
	input  pfrt_pkg::store_cmd_t cmd,
	output logic                rd_valid_s1,
	output pfrt_pkg::rule_t     rd_rule_s1
);
	import pfrt_pkg::*;

	logic [RULE_SLOTS-1:0] valid_q;
	rule_t                 mem [RULE_SLOTS];

	// per-slot valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[cmd.wr_idx] <= 1'b1;
			end
			if (cmd.clr_en) begin
				valid_q[cmd.clr_idx] <= 1'b0;
			end
			if (cmd.rd_en) begin
				rd_valid_s1 <= valid_q[cmd.rd_idx];
			end
		end
	end

	// rule payload, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_idx] <= cmd.wr_rule;
		end
		if (cmd.rd_en) begin
			rd_rule_s1 <= mem[cmd.rd_idx];
		end
	end

endmodule

// ===== sv/pfrt_scan_unit.sv =====
module pfrt_scan_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                eval,
	input  pfrt_pkg::in_item_t  item,
	input  pfrt_pkg::slot_idx_t slot_idx,
	input  logic                slot_valid,
	input  pfrt_pkg::rule_t     slot,
	output pfrt_pkg::scan_res_t res
);
	import pfrt_pkg::*;

	scan_res_t   res_q;
	scan_res_t   res_d;
	logic        l4;
	logic        match;
	logic [15:0] cmp_a;
	logic [15:0] cmp_b;
	logic        better;

	assign l4    = (item.protocol == PROTO_TCP) || (item.protocol == PROTO_UDP);
	assign match = slot_valid && slot.block &&
		((slot.protocol == item.protocol) || (l4 && (slot.port == item.port)));

	// one magnitude compare, operands swapped by mode:
	// classify looks for the lowest number, add for the highest
	assign cmp_a  = (item.mode == MODE_ADD) ? res_q.acc   : slot.number;
	assign cmp_b  = (item.mode == MODE_ADD) ? slot.number : res_q.acc;
	assign better = cmp_a < cmp_b;

	always_comb begin
		res_d = res_q;
		if (eval) begin
			case (item.mode)
				MODE_CLASSIFY: begin
					if (match && (!res_q.hit || better)) begin
						res_d.hit = 1'b1;
						res_d.acc = slot.number;
					end
				end
				MODE_ADD: begin
					if (slot_valid) begin
						if (!res_q.any || better) begin
							res_d.acc = slot.number;
						end
						res_d.any = 1'b1;
					end else if (!res_q.free_found) begin
						res_d.free_found = 1'b1;
						res_d.free_idx   = slot_idx;
					end
				end
				MODE_REMOVE: begin
					if (slot_valid && (slot.number == item.rule_id) && !res_q.found) begin
						res_d.found     = 1'b1;
						res_d.found_idx = slot_idx;
					end
				end
				default: begin
					res_d = res_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (start) begin
			res_q <= '0;
		end else begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule
